// File: src/sfla_pkg.sv
`default_nettype none
package sfla_pkg;

  localparam int ADDR_W = 16;
  localparam int SIZE_W = 13;
  localparam int PAGE_BYTES = 4096;
  localparam int MAX_PAGES = 16;
  localparam int MAX_BLOCKS_PER_PAGE = 512;
  localparam int LINK_SHIFT = 3;
  localparam int LINK_DEPTH = 8192;
  localparam int LINK_AW = $clog2(LINK_DEPTH);
  localparam int LINK_W = ADDR_W + 1;
  localparam int PAGE_W = $clog2(PAGE_BYTES);
  localparam int PAGES_W = $clog2(MAX_PAGES + 1);
  localparam int CNT_W = $clog2(MAX_BLOCKS_PER_PAGE);
  localparam int OFF_W = SIZE_W + 2;
  localparam logic [SIZE_W-1:0] MIN_SIZE = SIZE_W'(8);
  localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(8);

  localparam logic [1:0] ST_ALLOCATED = 2'd0;
  localparam logic [1:0] ST_FREED = 2'd1;
  localparam logic [1:0] ST_NULL_IGNORED = 2'd2;
  localparam logic [1:0] ST_OUT_OF_MEMORY = 2'd3;

  localparam logic MODE_ALLOC = 1'b0;
  localparam logic MODE_FREE = 1'b1;

  typedef struct packed {
    logic mode;
    logic [ADDR_W-1:0] address;
    logic address_valid;
  } in_req_t;

  typedef struct packed {
    logic [ADDR_W-1:0] block_address;
    logic [1:0] status;
  } out_res_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CARVE,
    S_READ,
    S_POP
  } state_t;

  typedef struct packed {
    logic do_free;
    logic do_null;
    logic do_oom;
    logic rd_head;
    logic pop;
    logic carve_init;
    logic carve_step;
  } cmd_t;

  typedef struct packed {
    logic head_valid;
    logic can_carve;
    logic carve_last;
  } stat_t;

endpackage
`default_nettype wire

// File: src/slab_free_list_allocator.sv
// A free, a null free or an out-of-memory allocate completes in S_IDLE; a new request may follow next.
// An allocate from a non-empty free list goes from S_IDLE to S_POP, bound by the registered link read.
// A carving allocate writes one link per block in S_CARVE, then passes through S_READ and S_POP.
// Each result is strobed on out_valid for one cycle, in the cycle after its request completes.
// Synchronous reset empties the list, frees all pages and sets object_size to 8.
// The link memory is not cleared at reset; the receiver cannot stall results.
`default_nettype none
module slab_free_list_allocator
  import sfla_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire in_req_t            in_data,
  input  wire logic               cfg_we,
  input  wire logic [SIZE_W-1:0]  cfg_wdata,
  output logic                    out_valid,
  output out_res_t                out_data
);

  cmd_t  cmd;
  stat_t stat;

  sfla_ctrl u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .mode          (in_data.mode),
    .address_valid (in_data.address_valid),
    .stat          (stat),
    .busy          (busy),
    .cmd           (cmd)
  );

  sfla_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .free_addr (in_data.address),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .stat      (stat),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire

// File: src/sfla_ctrl.sv
`default_nettype none
module sfla_ctrl
  import sfla_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    start,
  input  wire logic    mode,
  input  wire logic    address_valid,
  input  wire stat_t   stat,
  output logic         busy,
  output cmd_t         cmd
);

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (start && mode == MODE_ALLOC) begin
          if (stat.head_valid) begin
            state_nxt = S_POP;
          end else if (stat.can_carve) begin
            state_nxt = S_CARVE;
          end
        end
      end
      S_CARVE: begin
        if (stat.carve_last) begin
          state_nxt = S_READ;
        end
      end
      S_READ: state_nxt = S_POP;
      S_POP: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    busy = 1'b1;
    case (state_r)
      S_IDLE: begin
        busy = 1'b0;
        if (start) begin
          if (mode == MODE_FREE) begin
            cmd.do_free = address_valid;
            cmd.do_null = !address_valid;
          end else if (stat.head_valid) begin
            cmd.rd_head = 1'b1;
          end else if (stat.can_carve) begin
            cmd.carve_init = 1'b1;
          end else begin
            cmd.do_oom = 1'b1;
          end
        end
      end
      S_CARVE: cmd.carve_step = 1'b1;
      S_READ: cmd.rd_head = 1'b1;
      S_POP: cmd.pop = 1'b1;
      default: cmd = '0;
    endcase
  end

endmodule
`default_nettype wire

// File: src/sfla_dp.sv
`default_nettype none
module sfla_dp
  import sfla_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire cmd_t               cmd,
  input  wire logic [ADDR_W-1:0]  free_addr,
  input  wire logic               cfg_we,
  input  wire logic [SIZE_W-1:0]  cfg_wdata,
  output stat_t                   stat,
  output logic                    out_valid,
  output out_res_t                out_data
);

  logic [LINK_W-1:0] link_mem [LINK_DEPTH];
  logic [LINK_W-1:0] rdata_r;

  logic [SIZE_W-1:0] obj_size_r;
  logic              head_valid_r;
  logic              head_valid_nxt;
  logic [ADDR_W-1:0] head_r;
  logic [ADDR_W-1:0] head_nxt;
  logic [PAGES_W-1:0] pages_r;
  logic [PAGES_W-1:0] pages_nxt;
  logic [OFF_W-1:0]  off_r;
  logic [OFF_W-1:0]  off_nxt;
  logic [CNT_W-1:0]  cnt_r;
  logic [CNT_W-1:0]  cnt_nxt;
  logic              out_valid_r;
  logic              out_valid_nxt;
  out_res_t          out_r;
  out_res_t          out_nxt;

  logic [SIZE_W-1:0] eff_size;
  logic [OFF_W-1:0]  off_plus;
  logic [OFF_W-1:0]  off_plus2;
  logic [ADDR_W-1:0] base;
  logic [ADDR_W-1:0] cur_addr;
  logic [ADDR_W-1:0] nxt_addr;
  logic              has_next;
  logic              wr_en;
  logic [LINK_AW-1:0] wr_idx;
  logic [LINK_W-1:0] wr_data;

  assign eff_size = (obj_size_r < MIN_SIZE) ? MIN_SIZE : obj_size_r;
  assign off_plus = off_r + OFF_W'(eff_size);
  assign off_plus2 = off_plus + OFF_W'(eff_size);
  assign base = ADDR_W'(pages_r) << PAGE_W;
  assign cur_addr = base + ADDR_W'(off_r);
  assign nxt_addr = base + ADDR_W'(off_plus);
  assign has_next = (off_plus2 <= OFF_W'(PAGE_BYTES)) && (cnt_r != CNT_W'(MAX_BLOCKS_PER_PAGE - 1));

  assign stat.head_valid = head_valid_r;
  assign stat.can_carve = (pages_r < PAGES_W'(MAX_PAGES)) &&
                          (OFF_W'(eff_size) <= OFF_W'(PAGE_BYTES));
  assign stat.carve_last = !has_next;

  always_comb begin
    wr_en = 1'b0;
    wr_idx = free_addr[ADDR_W-1:LINK_SHIFT];
    wr_data = head_valid_r ? {1'b1, head_r} : '0;
    if (cmd.do_free) begin
      wr_en = 1'b1;
    end else if (cmd.carve_step) begin
      wr_en = 1'b1;
      wr_idx = cur_addr[ADDR_W-1:LINK_SHIFT];
      wr_data = has_next ? {1'b1, nxt_addr} : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      link_mem[wr_idx] <= wr_data;
    end
    if (cmd.rd_head) begin
      rdata_r <= link_mem[head_r[ADDR_W-1:LINK_SHIFT]];
    end
  end

  always_comb begin
    head_valid_nxt = head_valid_r;
    head_nxt = head_r;
    pages_nxt = pages_r;
    off_nxt = off_r;
    cnt_nxt = cnt_r;
    out_valid_nxt = 1'b0;
    out_nxt = out_r;
    if (cmd.do_free) begin
      head_valid_nxt = 1'b1;
      head_nxt = free_addr;
      out_valid_nxt = 1'b1;
      out_nxt.block_address = '0;
      out_nxt.status = ST_FREED;
    end
    if (cmd.do_null) begin
      out_valid_nxt = 1'b1;
      out_nxt.block_address = '0;
      out_nxt.status = ST_NULL_IGNORED;
    end
    if (cmd.do_oom) begin
      out_valid_nxt = 1'b1;
      out_nxt.block_address = '0;
      out_nxt.status = ST_OUT_OF_MEMORY;
    end
    if (cmd.carve_init) begin
      off_nxt = '0;
      cnt_nxt = '0;
    end
    if (cmd.carve_step) begin
      off_nxt = off_plus;
      cnt_nxt = cnt_r + CNT_W'(1);
      if (!has_next) begin
        head_valid_nxt = 1'b1;
        head_nxt = base;
        pages_nxt = pages_r + PAGES_W'(1);
      end
    end
    if (cmd.pop) begin
      head_valid_nxt = rdata_r[ADDR_W];
      head_nxt = rdata_r[ADDR_W] ? rdata_r[ADDR_W-1:0] : '0;
      out_valid_nxt = 1'b1;
      out_nxt.block_address = head_r;
      out_nxt.status = ST_ALLOCATED;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      obj_size_r <= SIZE_RESET;
      head_valid_r <= 1'b0;
      head_r <= '0;
      pages_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        obj_size_r <= cfg_wdata;
      end
      head_valid_r <= head_valid_nxt;
      head_r <= head_nxt;
      pages_r <= pages_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    off_r <= off_nxt;
    cnt_r <= cnt_nxt;
    out_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data = out_r;

endmodule
`default_nettype wire

// File: sim/tb_slab_free_list_allocator.sv
`default_nettype none
module tb_slab_free_list_allocator;
  timeunit 1ns;
  timeprecision 1ps;
  import sfla_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int NUM_PHASES = 9;

  // Free-list state kept alongside the block; one reply is expected per request.
  class free_list_model;
    logic [SIZE_W-1:0] object_size = SIZE_RESET;
    bit head_valid;
    bit [ADDR_W-1:0] head_block;
    bit [LINK_W-1:0] links [LINK_DEPTH];
    int unsigned pages_in_use;
    out_res_t pending_replies [$];
    bit [ADDR_W-1:0] live_blocks [$];
    int unsigned mismatches;
    int unsigned replies_checked;
    int unsigned status_seen [4];

    function bit carve_page();
      int unsigned blk;
      int unsigned count;
      int unsigned base;
      int unsigned i;
      bit [ADDR_W-1:0] cur;
      bit [ADDR_W-1:0] nxt;
      blk = 32'((object_size < MIN_SIZE) ? MIN_SIZE : object_size);
      count = PAGE_BYTES / blk;
      if (pages_in_use >= MAX_PAGES || count == 0) return 1'b0;
      if (count > MAX_BLOCKS_PER_PAGE) count = MAX_BLOCKS_PER_PAGE;
      base = pages_in_use * PAGE_BYTES;
      for (i = 0; i < count; i++) begin
        cur = ADDR_W'(base + i * blk);
        nxt = ADDR_W'(base + (i + 1) * blk);
        links[cur[ADDR_W-1:LINK_SHIFT]] = (i + 1 < count) ? {1'b1, nxt} : '0;
      end
      pages_in_use++;
      head_valid = 1'b1;
      head_block = ADDR_W'(base);
      return 1'b1;
    endfunction

    function void predict_request(in_req_t r);
      out_res_t want;
      bit [LINK_W-1:0] lk;
      want.block_address = '0;
      if (r.mode == MODE_ALLOC) begin
        if (!head_valid && !carve_page()) begin
          want.status = ST_OUT_OF_MEMORY;
        end else begin
          want.block_address = head_block;
          want.status = ST_ALLOCATED;
          live_blocks = {live_blocks, head_block};
          lk = links[head_block[ADDR_W-1:LINK_SHIFT]];
          head_valid = lk[ADDR_W];
          head_block = lk[ADDR_W] ? lk[ADDR_W-1:0] : '0;
        end
      end else if (!r.address_valid) begin
        want.status = ST_NULL_IGNORED;
      end else begin
        links[r.address[ADDR_W-1:LINK_SHIFT]] = head_valid ? {1'b1, head_block} : '0;
        head_valid = 1'b1;
        head_block = r.address;
        want.status = ST_FREED;
      end
      status_seen[want.status]++;
      pending_replies = {pending_replies, want};
    endfunction

    function void check_reply(out_res_t got);
      out_res_t want;
      if (pending_replies.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected reply: address %h status %0d", got.block_address, got.status);
        return;
      end
      want = pending_replies.pop_front();
      replies_checked++;
      if (got.block_address !== want.block_address || got.status !== want.status) begin
        mismatches++;
        if (mismatches <= 10)
          $display("reply mismatch: expected address %h status %0d, got address %h status %0d",
                   want.block_address, want.status, got.block_address, got.status);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  in_req_t in_data = '0;
  logic cfg_we = 1'b0;
  logic [SIZE_W-1:0] cfg_wdata = '0;
  logic out_valid;
  out_res_t out_data;

  free_list_model model = new;
  int unsigned cycles;

  slab_free_list_allocator dut (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_data(in_data),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata),
    .out_valid(out_valid),
    .out_data(out_data)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid) model.check_reply(out_data);
      if (start && !busy) model.predict_request(in_data);
    end
  end

  function automatic in_req_t make_request(logic mode, logic [ADDR_W-1:0] a, logic v);
    in_req_t r;
    r.mode = mode;
    r.address = a;
    r.address_valid = v;
    return r;
  endfunction

  task automatic send_request(input in_req_t r);
    @(negedge clk);
    in_data <= r;
    start <= 1'b1;
    do @(posedge clk); while (busy);
  endtask

  task automatic idle_for(input int n);
    @(negedge clk);
    start <= 1'b0;
    in_data <= in_req_t'($bits(in_req_t)'($urandom));
    repeat (n - 1) @(negedge clk);
  endtask

  task automatic settle();
    idle_for(1);
    while (model.pending_replies.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic write_object_size(input logic [SIZE_W-1:0] v);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    model.object_size = v;
  endtask

  initial begin
    in_req_t r;
    int burst;
    int pick;
    int idx;
    int unsigned total;
    logic [SIZE_W-1:0] phase_size [NUM_PHASES] = '{4095, 1500, 8191, 600, 100, 24, 0, 7, 8};
    int phase_alloc_pct [NUM_PHASES] = '{50, 50, 55, 60, 70, 75, 55, 60, 65};
    int phase_items [NUM_PHASES] = '{120, 120, 100, 150, 200, 250, 150, 150, 240};

    repeat (7) @(negedge clk);
    rst_n <= 1'b1;

    // An object larger than a page cannot be carved, so the allocate runs out of memory.
    write_object_size(8191);
    send_request(make_request(MODE_ALLOC, 16'hFFFF, 1'b1));
    send_request(make_request(MODE_FREE, 16'hFFFF, 1'b0));
    send_request(make_request(MODE_FREE, 16'h0000, 1'b0));
    settle();

    // One block per page: every allocate on an empty list carves a fresh page.
    write_object_size(4096);
    send_request(make_request(MODE_ALLOC, 16'h0000, 1'b0));
    send_request(make_request(MODE_ALLOC, 16'hFFFF, 1'b1));
    send_request(make_request(MODE_FREE, 16'h0000, 1'b1));
    send_request(make_request(MODE_ALLOC, 16'h5A5A, 1'b1));
    send_request(make_request(MODE_FREE, 16'hFFFF, 1'b1));
    send_request(make_request(MODE_FREE, 16'h0000, 1'b1));
    idle_for(3);
    send_request(make_request(MODE_ALLOC, 16'h0000, 1'b0));
    send_request(make_request(MODE_ALLOC, 16'h0000, 1'b0));
    send_request(make_request(MODE_ALLOC, 16'hA5A5, 1'b0));
    send_request(make_request(MODE_FREE, 16'h1234, 1'b0));

    for (int p = 0; p < NUM_PHASES; p++) begin
      settle();
      write_object_size(phase_size[p]);
      burst = $urandom_range(12, 1);
      for (int n = 0; n < phase_items[p]; n++) begin
        r.address = ADDR_W'($urandom);
        r.address_valid = 1'($urandom_range(1, 0));
        if ($urandom_range(99, 0) < phase_alloc_pct[p]) begin
          r.mode = MODE_ALLOC;
        end else begin
          r.mode = MODE_FREE;
          pick = $urandom_range(99, 0);
          if (pick < 10) begin
            r.address_valid = 1'b0;
          end else begin
            r.address_valid = 1'b1;
            if (pick >= 20 && model.live_blocks.size() != 0) begin
              idx = $urandom_range(model.live_blocks.size() - 1, 0);
              r.address = model.live_blocks[idx];
              model.live_blocks.delete(idx);
            end
          end
        end
        send_request(r);
        burst--;
        if (burst == 0) begin
          idle_for($urandom_range(8, 1));
          burst = ($urandom_range(4, 0) == 0) ? $urandom_range(60, 30) : $urandom_range(12, 1);
        end
      end
    end

    settle();
    repeat (8) @(posedge clk);
    model.mismatches += model.pending_replies.size();

    total = model.status_seen[0] + model.status_seen[1] + model.status_seen[2] +
            model.status_seen[3];
    $display("Ran %0d requests over %0d object sizes, %0d pages carved, %0d replies checked.",
             total, NUM_PHASES + 2, model.pages_in_use, model.replies_checked);
    $display("Allocated %0d, freed %0d, null frees %0d, out of memory %0d, mismatches %0d.",
             model.status_seen[ST_ALLOCATED], model.status_seen[ST_FREED],
             model.status_seen[ST_NULL_IGNORED], model.status_seen[ST_OUT_OF_MEMORY],
             model.mismatches);
    if (model.mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
`default_nettype wire
